/* rtl/tccw_pkg.sv */
// Shared types, constants and address helper for the text console cell writer.
// Used by text_console_cell_writer; depends on nothing else.
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int CELL_W     = 16;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int PTR_W      = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS + 1);

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;

    typedef enum logic [1:0] {
        OP_PUT       = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  char_code;
        logic [4:0]  read_row;
        logic [6:0]  read_column;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_column_out;
    } t_out_item;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [PTR_W-1:0] row,
                                                    input logic [PTR_W-1:0] col);
        logic [PTR_W-1:0] lin;
        lin = row * PTR_W'(COLUMNS) + col;
        return lin[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/tccw_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; no package needed.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/text_console_cell_writer.sv */
// Text console cell writer: a character-cell screen store with a write cursor.
// Depends on tccw_pkg and instantiates tccw_ram for the screen store.
//
// After reset the block sweeps the screen store to blanks, one cell a cycle, and takes
// no item until the sweep is done; configuration writes are taken at any time. Every
// item returns one result item. A put character or backspace passes through a cell
// write state, and a cell read through a RAM read state, before the result register
// is loaded; a newline that does not scroll, or a backspace at column zero, loads it
// directly. A scroll streams the store through the single RAM port pair one cell a
// cycle: a newline on the last row moves every row up one and blanks the bottom row,
// then writes any character that wrapped into the scroll; a clear blanks the store.
// A new item is accepted while the previous result still waits in the output register.
module text_console_cell_writer
    import tccw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WRITE,
        S_READ,
        S_SCROLL,
        S_BLANK,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [7:0]        r_attr, n_attr;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [PTR_W-1:0]  r_last, n_last;
    logic              r_cp_valid, n_cp_valid;
    logic [ADDR_W-1:0] r_cp_addr, n_cp_addr;
    logic [7:0]        r_wchar, n_wchar;
    logic              r_adv, n_adv;
    logic              r_put_pending, n_put_pending;
    logic              r_rd_ok, n_rd_ok;
    logic [7:0]        r_rd_char, n_rd_char;
    logic [7:0]        r_rd_attr, n_rd_attr;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic [PTR_W-1:0]  cp_src_minus;
    logic              last_row;

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cp_src_minus = r_ptr - PTR_W'(COLUMNS);
    assign last_row     = (r_row == ROW_W'(ROWS - 1));

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_col         = r_col;
        n_attr        = r_attr;
        n_ptr         = r_ptr;
        n_last        = r_last;
        n_cp_valid    = r_cp_valid;
        n_cp_addr     = r_cp_addr;
        n_wchar       = r_wchar;
        n_adv         = r_adv;
        n_put_pending = r_put_pending;
        n_rd_ok       = r_rd_ok;
        n_rd_char     = r_rd_char;
        n_rd_attr     = r_rd_attr;
        n_out_valid   = r_out_valid;
        n_out_item    = r_out_item;
        ram_we        = 1'b0;
        ram_waddr     = r_ptr[ADDR_W-1:0];
        ram_wdata     = {BLANK_CHAR, r_attr};
        ram_raddr     = r_ptr[ADDR_W-1:0];

        if (i_cfg_valid) begin
            n_attr = i_cfg_data;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {BLANK_CHAR, RESET_ATTR};
                n_ptr     = r_ptr + 1'b1;
                if (r_ptr == PTR_W'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = cell_addr(PTR_W'(i_in_item.read_row),
                                      PTR_W'(i_in_item.read_column));
                if (i_in_valid) begin
                    n_rd_char     = 8'd0;
                    n_rd_attr     = 8'd0;
                    n_put_pending = 1'b0;
                    case (i_in_item.opcode)
                        OP_PUT: begin
                            if (i_in_item.char_code == NEWLINE_CHAR) begin
                                n_col = '0;
                                if (last_row) begin
                                    n_ptr      = PTR_W'(COLUMNS);
                                    n_cp_valid = 1'b0;
                                    n_state    = S_SCROLL;
                                end else begin
                                    n_row   = r_row + 1'b1;
                                    n_state = S_DONE;
                                end
                            end else begin
                                n_wchar = i_in_item.char_code;
                                n_adv   = 1'b1;
                                if (r_col >= COL_W'(COLUMNS)) begin
                                    n_col = '0;
                                    if (last_row) begin
                                        n_ptr         = PTR_W'(COLUMNS);
                                        n_cp_valid    = 1'b0;
                                        n_put_pending = 1'b1;
                                        n_state       = S_SCROLL;
                                    end else begin
                                        n_row   = r_row + 1'b1;
                                        n_state = S_WRITE;
                                    end
                                end else begin
                                    n_state = S_WRITE;
                                end
                            end
                        end
                        OP_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col   = r_col - 1'b1;
                                n_wchar = BLANK_CHAR;
                                n_adv   = 1'b0;
                                n_state = S_WRITE;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_ptr   = '0;
                            n_last  = PTR_W'(CELL_COUNT - 1);
                            n_state = S_BLANK;
                        end
                        OP_READ: begin
                            n_rd_ok = (int'(i_in_item.read_row) < ROWS) &&
                                      (int'(i_in_item.read_column) < COLUMNS);
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(PTR_W'(r_row), PTR_W'(r_col));
                ram_wdata = {r_wchar, r_attr};
                if (r_adv) begin
                    n_col = r_col + 1'b1;
                end
                n_state = S_DONE;
            end
            S_READ: begin
                if (r_rd_ok) begin
                    n_rd_char = ram_rdata[15:8];
                    n_rd_attr = ram_rdata[7:0];
                end
                n_state = S_DONE;
            end
            S_SCROLL: begin
                // Each cell read here is written one row up in the following cycle.
                ram_we     = r_cp_valid;
                ram_waddr  = r_cp_addr;
                ram_wdata  = ram_rdata;
                n_cp_addr  = cp_src_minus[ADDR_W-1:0];
                n_cp_valid = (r_ptr < PTR_W'(CELL_COUNT));
                n_ptr      = r_ptr + 1'b1;
                if (r_ptr == PTR_W'(CELL_COUNT)) begin
                    n_ptr      = PTR_W'(CELL_COUNT - COLUMNS);
                    n_last     = PTR_W'(CELL_COUNT - 1);
                    n_cp_valid = 1'b0;
                    n_state    = S_BLANK;
                end
            end
            S_BLANK: begin
                ram_we = 1'b1;
                n_ptr  = r_ptr + 1'b1;
                if (r_ptr == r_last) begin
                    n_put_pending = 1'b0;
                    n_state       = r_put_pending ? S_WRITE : S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                  = 1'b1;
                    n_out_item.cell_char         = r_rd_char;
                    n_out_item.cell_attr         = r_rd_attr;
                    n_out_item.cursor_row_out    = 5'(r_row);
                    n_out_item.cursor_column_out = 7'(r_col);
                    n_state                      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_last    <= n_last;
        r_cp_addr <= n_cp_addr;
        r_wchar   <= n_wchar;
        r_adv     <= n_adv;
        r_rd_ok   <= n_rd_ok;
        r_rd_char <= n_rd_char;
        r_rd_attr <= n_rd_attr;
        r_out_item <= n_out_item;
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_row         <= '0;
            r_col         <= '0;
            r_attr        <= RESET_ATTR;
            r_ptr         <= '0;
            r_cp_valid    <= 1'b0;
            r_put_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_row         <= n_row;
            r_col         <= n_col;
            r_attr        <= n_attr;
            r_ptr         <= n_ptr;
            r_cp_valid    <= n_cp_valid;
            r_put_pending <= n_put_pending;
            r_out_valid   <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COLUMNS))
        else $error("cursor column beyond the wrap position");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_row) < ROWS)
        else $error("cursor row beyond the last row");

    a_write_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> r_col < COL_W'(COLUMNS))
        else $error("cell write with a pending wrap");

    a_scroll_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_cp_valid) |-> int'(r_cp_addr) < CELL_COUNT - COLUMNS)
        else $error("scroll copy writes into the bottom row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_item)))
        else $error("waiting result item overwritten");

endmodule
